### hdl/ils_pkg.sv
// Shared types and codes for the indexed list store.
// Operation and status codes, default sizes and the per-cell control bundle.
// No dependencies.
`timescale 1ns / 1ps

package ils_pkg;

	localparam int CAPACITY_DEF    = 64;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int FUNC_W          = 3;
	localparam int STATUS_W        = 3;

	localparam logic [FUNC_W-1:0] FN_INSERT   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_APPEND   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_LAST = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ     = 3'd4;
	localparam logic [FUNC_W-1:0] FN_FIND     = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd1;
	localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_MISS      = 3'd4;

	typedef struct packed {
		logic ins;
		logic del;
		logic sel;
		logic find;
	} cell_ctl_t;

endpackage

### hdl/ils_cell.sv
// One storage cell of the list: holds a single entry and one stage of the
// search carry. Depends on ils_pkg for the control bundle.
`timescale 1ns / 1ps

module ils_cell #(
	parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF,
	parameter int POS         = 0,
	localparam int POS_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ils_pkg::cell_ctl_t     ctl,
	input  logic [CNT_W-1:0]       eff_idx,
	input  logic [VALUE_WIDTH-1:0] key,
	input  logic [CNT_W-1:0]       count,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic [VALUE_WIDTH-1:0] right_value,
	output logic [VALUE_WIDTH-1:0] value,
	input  logic                   hit_in,
	input  logic [VALUE_WIDTH-1:0] data_in,
	input  logic [POS_W-1:0]       pos_in,
	output logic                   hit_out,
	output logic [VALUE_WIDTH-1:0] data_out,
	output logic [POS_W-1:0]       pos_out
);

	localparam logic [CNT_W-1:0] MY_POS = CNT_W'(POS);

	logic [VALUE_WIDTH-1:0] entry_q;
	logic                   hit_q;
	logic [VALUE_WIDTH-1:0] data_q;
	logic [POS_W-1:0]       pos_q;
	logic                   match;

	assign match = (ctl.sel && (MY_POS == eff_idx)) ||
		(ctl.find && (MY_POS < count) && (entry_q == key));

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_POS > eff_idx) begin
				entry_q <= left_value;
			end else if (MY_POS == eff_idx) begin
				entry_q <= key;
			end
		end else if (ctl.del && (MY_POS >= eff_idx)) begin
			entry_q <= right_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= hit_in || match;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_in) begin
			data_q <= data_in;
			pos_q  <= pos_in;
		end else begin
			data_q <= entry_q;
			pos_q  <= POS_W'(POS);
		end
	end

	assign value    = entry_q;
	assign hit_out  = hit_q;
	assign data_out = data_q;
	assign pos_out  = pos_q;

endmodule

### hdl/ils_ctrl.sv
// Sequencer of the list: command latch, range checks, carry walk timing,
// entry count and result registers. Depends on ils_pkg.
`timescale 1ns / 1ps

module ils_ctrl #(
	parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF,
	localparam int POS_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ils_pkg::FUNC_W-1:0]   func,
	input  logic [POS_W-1:0]             list_index,
	input  logic [VALUE_WIDTH-1:0]       item_value,
	output logic                         done,
	output logic [ils_pkg::STATUS_W-1:0] status,
	output logic [VALUE_WIDTH-1:0]       data_out,
	output logic [POS_W-1:0]             found_position,
	output logic [CNT_W-1:0]             entry_count,
	output logic                         is_empty,
	output ils_pkg::cell_ctl_t           cell_ctl,
	output logic [CNT_W-1:0]             eff_idx,
	output logic [VALUE_WIDTH-1:0]       key,
	output logic [CNT_W-1:0]             count,
	input  logic                         tail_hit,
	input  logic [VALUE_WIDTH-1:0]       tail_data,
	input  logic [POS_W-1:0]             tail_pos
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]                   state_q;
	logic [ils_pkg::FUNC_W-1:0]   op_q;
	logic [POS_W-1:0]             idx_q;
	logic [VALUE_WIDTH-1:0]       val_q;
	logic [CNT_W-1:0]             count_q;
	logic [POS_W-1:0]             walk_q;
	logic                         done_q;
	logic [ils_pkg::STATUS_W-1:0] status_q;
	logic [VALUE_WIDTH-1:0]       data_q;
	logic [POS_W-1:0]             pos_q;

	logic is_full;
	logic idx_over;
	logic idx_out;
	logic is_add;
	logic is_del;
	logic ins_ok;

	always_comb begin
		unique case (op_q)
			ils_pkg::FN_APPEND:   eff_idx = count_q;
			ils_pkg::FN_DEL_LAST: eff_idx = count_q - CNT_W'(1);
			default:              eff_idx = CNT_W'(idx_q);
		endcase
	end

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign idx_over = (eff_idx > count_q);
	assign idx_out  = (eff_idx >= count_q);
	assign is_add   = (op_q == ils_pkg::FN_INSERT) || (op_q == ils_pkg::FN_APPEND);
	assign is_del   = (op_q == ils_pkg::FN_DELETE) || (op_q == ils_pkg::FN_DEL_LAST);
	assign ins_ok   = is_add && (val_q != '0) && !idx_over && !is_full;

	assign cell_ctl.ins  = (state_q == S_EXEC) && ins_ok;
	assign cell_ctl.del  = (state_q == S_FIN) && is_del;
	assign cell_ctl.sel  = is_del || (op_q == ils_pkg::FN_READ);
	assign cell_ctl.find = (op_q == ils_pkg::FN_FIND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			walk_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					walk_q <= '0;
					unique case (op_q)
						ils_pkg::FN_INSERT, ils_pkg::FN_APPEND: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
							if (ins_ok) begin
								count_q <= count_q + CNT_W'(1);
							end
						end
						ils_pkg::FN_DELETE, ils_pkg::FN_READ: begin
							if (idx_out) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_WALK;
							end
						end
						ils_pkg::FN_DEL_LAST: begin
							if (count_q == '0) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_WALK;
							end
						end
						ils_pkg::FN_FIND: begin
							state_q <= S_WALK;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_WALK: begin
					if (walk_q == POS_W'(CAPACITY - 1)) begin
						state_q <= S_FIN;
					end else begin
						walk_q <= walk_q + POS_W'(1);
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (is_del) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && start) begin
			op_q  <= func;
			idx_q <= list_index;
			val_q <= item_value;
		end
		if (state_q == S_EXEC) begin
			data_q   <= '0;
			pos_q    <= '0;
			status_q <= ils_pkg::ST_OK;
			unique case (op_q)
				ils_pkg::FN_INSERT, ils_pkg::FN_APPEND: begin
					if (val_q == '0) begin
						status_q <= ils_pkg::ST_ZERO;
					end else if (idx_over) begin
						status_q <= ils_pkg::ST_BAD_INDEX;
					end else if (is_full) begin
						status_q <= ils_pkg::ST_FULL;
					end
				end
				ils_pkg::FN_DELETE, ils_pkg::FN_READ: begin
					if (idx_out) begin
						status_q <= ils_pkg::ST_BAD_INDEX;
					end
				end
				ils_pkg::FN_DEL_LAST: begin
					if (count_q == '0) begin
						status_q <= ils_pkg::ST_MISS;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == S_FIN) begin
			if (op_q == ils_pkg::FN_FIND) begin
				if (tail_hit) begin
					pos_q <= tail_pos;
				end else begin
					status_q <= ils_pkg::ST_MISS;
				end
			end else begin
				data_q <= tail_data;
			end
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign data_out       = data_q;
	assign found_position = pos_q;
	assign entry_count    = count_q;
	assign is_empty       = (count_q == '0);
	assign key            = val_q;
	assign count          = count_q;

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.ins |-> (count_q != CNT_W'(CAPACITY)))
		else $error("insert shift into a full list");

	a_del_held: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.del |-> (count_q != '0))
		else $error("delete shift from an empty list");
`endif

endmodule

### hdl/indexed_list_store.sv
// Ordered list of CAPACITY entries in a row of cells. Insert, append, unused codes and
// failed checks end in the execute state. Delete, delete last, read and find go on to a
// walk state, where the search carry steps one cell per cycle, and a finish state. One
// item at a time; a new start is taken in the cycle done is high. done lasts one cycle,
// the receiver cannot stall. Reset empties the list; entry contents are not cleared.
`timescale 1ns / 1ps

module indexed_list_store #(
	parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = ils_pkg::VALUE_WIDTH_DEF,
	localparam int POS_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [ils_pkg::FUNC_W-1:0]   func,
	input  logic [POS_W-1:0]             list_index,
	input  logic [VALUE_WIDTH-1:0]       item_value,
	output logic                         done,
	output logic [ils_pkg::STATUS_W-1:0] status,
	output logic [VALUE_WIDTH-1:0]       data_out,
	output logic [POS_W-1:0]             found_position,
	output logic [CNT_W-1:0]             entry_count,
	output logic                         is_empty
);

	ils_pkg::cell_ctl_t     cell_ctl;
	logic [CNT_W-1:0]       eff_idx;
	logic [VALUE_WIDTH-1:0] key;
	logic [CNT_W-1:0]       count;

	logic [VALUE_WIDTH-1:0] value_w [CAPACITY];
	logic                   hit_w   [CAPACITY+1];
	logic [VALUE_WIDTH-1:0] data_w  [CAPACITY+1];
	logic [POS_W-1:0]       pos_w   [CAPACITY+1];

	assign hit_w[0]  = 1'b0;
	assign data_w[0] = '0;
	assign pos_w[0]  = '0;

	ils_ctrl #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.list_index     (list_index),
		.item_value     (item_value),
		.done           (done),
		.status         (status),
		.data_out       (data_out),
		.found_position (found_position),
		.entry_count    (entry_count),
		.is_empty       (is_empty),
		.cell_ctl       (cell_ctl),
		.eff_idx        (eff_idx),
		.key            (key),
		.count          (count),
		.tail_hit       (hit_w[CAPACITY]),
		.tail_data      (data_w[CAPACITY]),
		.tail_pos       (pos_w[CAPACITY])
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_v;
		logic [VALUE_WIDTH-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = value_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = value_w[i];
		end else begin : g_mid_r
			assign right_v = value_w[i+1];
		end

		ils_cell #(
			.CAPACITY    (CAPACITY),
			.VALUE_WIDTH (VALUE_WIDTH),
			.POS         (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (cell_ctl),
			.eff_idx     (eff_idx),
			.key         (key),
			.count       (count),
			.left_value  (left_v),
			.right_value (right_v),
			.value       (value_w[i]),
			.hit_in      (hit_w[i]),
			.data_in     (data_w[i]),
			.pos_in      (pos_w[i]),
			.hit_out     (hit_w[i+1]),
			.data_out    (data_w[i+1]),
			.pos_out     (pos_w[i+1])
		);
	end

endmodule
